// ===== design/hpe_pkg.sv =====
// shared constants, codes and types of the polynomial evaluator
package hpe_pkg;

    localparam int MAX_DEGREE = 12;
    localparam int TABLE_SIZE = MAX_DEGREE + 1;
    localparam int DEG_W      = 4;
    localparam int COEF_W     = 32;
    localparam int X_W        = 32;
    localparam int ACC_W      = 64;
    localparam int K_W        = COEF_W + DEG_W + 1;
    localparam int FRAC_W     = 16;
    localparam int PROD_W     = ACC_W + X_W + 1;
    localparam int SUM_W      = PROD_W - FRAC_W;
    localparam int CNT_W      = $clog2(X_W);

    typedef enum logic [1:0] {
        CMD_SET_DEG = 2'd0,
        CMD_WRITE   = 2'd1,
        CMD_READ    = 2'd2,
        CMD_EVAL    = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_BAD_DEG = 2'd1,
        ST_BAD_IDX = 2'd2,
        ST_SAT     = 2'd3
    } t_status;

    typedef struct packed {
        logic start;
        logic step;
        logic x_bit;
        logic neg;
    } t_mul_ctl;

endpackage

// ===== design/hpe_if.sv =====
// valid/ready channel interfaces for command and result transactions
interface hpe_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  cmd;
    logic [3:0]  new_degree;
    logic [3:0]  coef_index;
    logic signed [31:0] coef_value;
    logic signed [31:0] point_x;

    modport source (output valid, cmd, new_degree, coef_index, coef_value, point_x,
                    input ready);
    modport sink   (input valid, cmd, new_degree, coef_index, coef_value, point_x,
                    output ready);
endinterface

interface hpe_out_if;
    logic        valid;
    logic        ready;
    logic signed [63:0] poly_value;
    logic signed [63:0] deriv_value;
    logic signed [31:0] coef_read;
    logic [3:0]  degree_now;
    logic [1:0]  status;

    modport source (output valid, poly_value, deriv_value, coef_read, degree_now, status,
                    input ready);
    modport sink   (input valid, poly_value, deriv_value, coef_read, degree_now, status,
                     output ready);
endinterface

// ===== design/hpe_mul.sv =====
// bit-serial multiply by x followed by shift, add and saturate of one horner step
module hpe_mul
    import hpe_pkg::*;
(
    input  logic                    i_clk,
    input  t_mul_ctl                i_ctl,
    input  logic signed [ACC_W-1:0] i_acc,
    input  logic signed [K_W-1:0]   i_k,
    output logic signed [ACC_W-1:0] o_res,
    output logic                    o_sat
);

    logic signed [PROD_W-1:0] r_prod;
    logic signed [PROD_W-1:0] n_prod;
    logic signed [PROD_W-1:0] addend;
    logic signed [SUM_W-1:0]  sum;

    always_comb begin
        addend = '0;
        if (i_ctl.x_bit) begin
            addend = PROD_W'(i_acc) <<< X_W;
            if (i_ctl.neg) begin
                addend = -addend;
            end
        end
        n_prod = (r_prod + addend) >>> 1;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_prod <= '0;
        end else if (i_ctl.step) begin
            r_prod <= n_prod;
        end
    end

    always_comb begin
        sum   = SUM_W'(r_prod >>> FRAC_W) + (SUM_W'(i_k) <<< FRAC_W);
        o_sat = (sum[SUM_W-1:ACC_W-1] != '0) && (sum[SUM_W-1:ACC_W-1] != '1);
        if (!o_sat) begin
            o_res = sum[ACC_W-1:0];
        end else if (sum[SUM_W-1]) begin
            o_res = {1'b1, {(ACC_W-1){1'b0}}};
        end else begin
            o_res = {1'b0, {(ACC_W-1){1'b1}}};
        end
    end

endmodule

// ===== design/polynomial_evaluator_with_derivative.sv =====
// top level: coefficient table, command sequencer and two serial horner units
// Commands arrive on i_in (valid/ready); one result transaction per command
// leaves on o_out. Set degree, write and read go from acceptance through
// the done state to a valid result in the output register. Evaluate at
// degree d runs d horner steps, p(x) and p'(x) side by side; each step is
// a table read (S_LOAD), a bit-serial multiply by x over its 32 bits (one
// bit of x per cycle) and an add and saturate (S_FIN). The serial multiply
// over the bits of x takes most of the time of each step.
// One command is in flight at a time; i_in.ready is high while the
// sequencer is idle, also while a finished result still waits on o_out.
// If the receiver stalls, a second result waits in the sequencer until
// the output register frees, and no further command is taken meanwhile.
// Reset clears the table, the degree, and the output valid.
module polynomial_evaluator_with_derivative
    import hpe_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    hpe_in_if.sink    i_in,
    hpe_out_if.source o_out
);

    typedef enum logic [2:0] {S_IDLE, S_LOAD, S_MUL, S_FIN, S_DONE} t_state;

    t_state                  r_state;
    logic [COEF_W-1:0]       r_tab [TABLE_SIZE];
    logic [DEG_W-1:0]        r_deg;
    logic [DEG_W-1:0]        r_j;
    logic [CNT_W-1:0]        r_cnt;
    logic [X_W-1:0]          r_x;
    logic [X_W-1:0]          r_xs;
    logic signed [K_W-1:0]   r_kp;
    logic signed [K_W-1:0]   r_kd;
    logic signed [ACC_W-1:0] r_pacc;
    logic signed [ACC_W-1:0] r_dacc;
    logic signed [COEF_W-1:0] r_rd;
    t_status                 r_status;
    logic                    r_ov;
    logic signed [ACC_W-1:0] r_op;
    logic signed [ACC_W-1:0] r_od;
    logic signed [COEF_W-1:0] r_ord;
    logic [DEG_W-1:0]        r_odeg;
    t_status                 r_ost;

    logic                    in_acc;
    logic [DEG_W-1:0]        rd_addr;
    logic signed [COEF_W-1:0] rd_data;
    logic [DEG_W-1:0]        jm1;
    logic signed [K_W-1:0]   kd_new;
    t_mul_ctl                ctl;
    logic signed [ACC_W-1:0] p_res;
    logic signed [ACC_W-1:0] d_res;
    logic                    p_sat;
    logic                    d_sat;
    t_cmd                    cmd;

    assign cmd     = t_cmd'(i_in.cmd);
    assign in_acc  = i_in.valid && i_in.ready;
    assign i_in.ready = (r_state == S_IDLE);
    assign jm1     = r_j - 1'b1;

    always_comb begin
        if (r_state == S_IDLE) begin
            rd_addr = (cmd == CMD_READ) ? i_in.coef_index : r_deg;
        end else begin
            rd_addr = jm1;
        end
        rd_data = (rd_addr <= DEG_W'(MAX_DEGREE)) ? r_tab[rd_addr] : '0;
    end

    assign kd_new = K_W'(rd_data) * $signed({1'b0, jm1});

    always_comb begin
        ctl.start = (r_state == S_LOAD);
        ctl.step  = (r_state == S_MUL);
        ctl.x_bit = r_xs[0];
        ctl.neg   = (r_cnt == CNT_W'(X_W - 1));
    end

    hpe_mul u_pmul (
        .i_clk (i_clk),
        .i_ctl (ctl),
        .i_acc (r_pacc),
        .i_k   (r_kp),
        .o_res (p_res),
        .o_sat (p_sat)
    );

    hpe_mul u_dmul (
        .i_clk (i_clk),
        .i_ctl (ctl),
        .i_acc (r_dacc),
        .i_k   (r_kd),
        .o_res (d_res),
        .o_sat (d_sat)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_deg   <= '0;
            r_ov    <= 1'b0;
            for (int i = 0; i < TABLE_SIZE; i++) begin
                r_tab[i] <= '0;
            end
        end else begin
            if (r_state == S_DONE && (!r_ov || o_out.ready)) begin
                r_ov <= 1'b1;
            end else if (o_out.ready) begin
                r_ov <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_pacc   <= '0;
                        r_dacc   <= '0;
                        r_rd     <= '0;
                        r_status <= ST_OK;
                        r_state  <= S_DONE;
                        case (cmd)
                            CMD_SET_DEG: begin
                                if (i_in.new_degree > DEG_W'(MAX_DEGREE)) begin
                                    r_status <= ST_BAD_DEG;
                                end else begin
                                    r_deg <= i_in.new_degree;
                                    for (int i = 0; i < TABLE_SIZE; i++) begin
                                        if (DEG_W'(i) > i_in.new_degree) begin
                                            r_tab[i] <= '0;
                                        end
                                    end
                                end
                            end
                            CMD_WRITE: begin
                                if (i_in.coef_index > DEG_W'(MAX_DEGREE)) begin
                                    r_status <= ST_BAD_IDX;
                                end else begin
                                    r_tab[i_in.coef_index] <= i_in.coef_value;
                                end
                            end
                            CMD_READ: begin
                                if (i_in.coef_index > DEG_W'(MAX_DEGREE)) begin
                                    r_status <= ST_BAD_IDX;
                                end else begin
                                    r_rd <= rd_data;
                                end
                            end
                            default: begin
                                r_x    <= i_in.point_x;
                                r_j    <= r_deg;
                                r_pacc <= ACC_W'(rd_data) <<< FRAC_W;
                                r_dacc <= (ACC_W'(rd_data) * $signed({1'b0, r_deg}))
                                          <<< FRAC_W;
                                if (r_deg != '0) begin
                                    r_state <= S_LOAD;
                                end
                            end
                        endcase
                    end
                end
                S_LOAD: begin
                    r_kp    <= K_W'(rd_data);
                    r_kd    <= kd_new;
                    r_xs    <= r_x;
                    r_cnt   <= '0;
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    r_xs  <= r_xs >> 1;
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == CNT_W'(X_W - 1)) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    r_pacc <= p_res;
                    if (r_j >= DEG_W'(2)) begin
                        r_dacc <= d_res;
                    end
                    if (p_sat || (d_sat && r_j >= DEG_W'(2))) begin
                        r_status <= ST_SAT;
                    end
                    r_j     <= jm1;
                    r_state <= (jm1 == '0) ? S_DONE : S_LOAD;
                end
                S_DONE: begin
                    if (!r_ov || o_out.ready) begin
                        r_op    <= r_pacc;
                        r_od    <= r_dacc;
                        r_ord   <= r_rd;
                        r_odeg  <= r_deg;
                        r_ost   <= r_status;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out.valid       = r_ov;
    assign o_out.poly_value  = r_op;
    assign o_out.deriv_value = r_od;
    assign o_out.coef_read   = r_ord;
    assign o_out.degree_now  = r_odeg;
    assign o_out.status      = r_ost;

`ifndef ASSERT_OFF
    a_deg_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_deg <= DEG_W'(MAX_DEGREE))
        else $error("degree register out of range");
    a_short_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && cmd != CMD_EVAL |=> r_state == S_DONE)
        else $error("short command did not finish in one cycle");
    a_sat_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_FIN && p_sat |=> r_status == ST_SAT)
        else $error("saturation not recorded");
    a_mul_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_LOAD |=> r_state == S_MUL && r_cnt == '0)
        else $error("serial multiply did not start cleanly");
`endif

endmodule
